### rtl/core/keyboard_matrix_port_scan_macros.svh
// Assertion macros for the keyboard matrix port scan checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef KEYBOARD_MATRIX_PORT_SCAN_MACROS_SVH
`define KEYBOARD_MATRIX_PORT_SCAN_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KMPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define KMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/kmps_pkg.sv
// Shared types and constants for the keyboard matrix port scan block.
// No dependencies; used by every module of the block.
package kmps_pkg;

	typedef enum logic [1:0] {
		ACT_PRESS   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_WRITE   = 2'd2,
		ACT_READ    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_PORT_A = 2'd0,
		REG_PORT_B = 2'd1,
		REG_DIR_A  = 2'd2,
		REG_DIR_B  = 2'd3
	} reg_addr_t;

	localparam int unsigned GROUPS = 8;
	localparam logic [2:0] SHIFT_GROUP = 3'd6;
	localparam logic [2:0] SHIFT_BIT   = 3'd4;
	localparam logic [7:0] NO_KEYS     = 8'hFF;

	typedef struct packed {
		logic [GROUPS-1:0][7:0] key_map;
		logic [7:0]             port_a;
		logic [7:0]             port_b;
		logic [7:0]             dir_a;
		logic [7:0]             dir_b;
	} port_state_t;

	typedef struct packed {
		logic       valid;
		action_t    action;
		logic [2:0] key_group;
		logic [2:0] key_bit;
		logic       with_shift;
		reg_addr_t  reg_address;
		logic [7:0] write_value;
	} item_t;

endpackage

### rtl/core/kmps_state.sv
// Key map and port/direction registers, updated by press, release and write items.
// Depends on kmps_pkg.
module kmps_state (
	input  logic                clk,
	input  logic                arst_n,
	input  kmps_pkg::item_t     upd,
	output kmps_pkg::port_state_t state
);

	kmps_pkg::port_state_t state_q;
	kmps_pkg::port_state_t state_d;
	logic                  is_key;
	logic                  level;

	always_comb begin
		is_key  = (upd.action == kmps_pkg::ACT_PRESS) || (upd.action == kmps_pkg::ACT_RELEASE);
		// active-low map: release sets, press clears
		level   = (upd.action == kmps_pkg::ACT_RELEASE);
		state_d = state_q;
		if (upd.valid && is_key) begin
			if (upd.with_shift) begin
				state_d.key_map[kmps_pkg::SHIFT_GROUP][kmps_pkg::SHIFT_BIT] = level;
			end
			state_d.key_map[upd.key_group][upd.key_bit] = level;
		end
		if (upd.valid && upd.action == kmps_pkg::ACT_WRITE) begin
			unique case (upd.reg_address)
				kmps_pkg::REG_PORT_A: state_d.port_a = upd.write_value;
				kmps_pkg::REG_PORT_B: state_d.port_b = upd.write_value;
				kmps_pkg::REG_DIR_A:  state_d.dir_a  = upd.write_value;
				kmps_pkg::REG_DIR_B:  state_d.dir_b  = upd.write_value;
				default:              state_d.dir_b  = upd.write_value;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.key_map <= {kmps_pkg::GROUPS{kmps_pkg::NO_KEYS}};
			state_q.port_a  <= 8'h00;
			state_q.port_b  <= 8'h00;
			state_q.dir_a   <= 8'h00;
			state_q.dir_b   <= 8'h00;
		end else begin
			state_q <= state_d;
		end
	end

	assign state = state_q;

endmodule

### rtl/core/kmps_scan.sv
// Read path: matrix scan of port A and port B, and direction readback.
// Depends on kmps_pkg.
module kmps_scan (
	input  kmps_pkg::port_state_t state,
	input  kmps_pkg::reg_addr_t   reg_address,
	output logic [7:0]            read_value
);

	logic [7:0] sel_a;
	logic [7:0] sel_b;
	logic [7:0] hit_a;
	logic [7:0] col_b;
	logic [7:0] scan_a;
	logic [7:0] scan_b;

	always_comb begin
		sel_a = state.port_a | ~state.dir_a;
		sel_b = state.port_b | ~state.dir_b;
		col_b = kmps_pkg::NO_KEYS;
		for (int g = 0; g < kmps_pkg::GROUPS; g++) begin
			// group line g pulled low by any pressed key on a driven-low bit line
			hit_a[g] = |(~state.key_map[g] & ~sel_b);
			col_b    = col_b & (state.key_map[g] | {8{sel_a[g]}});
		end
		scan_a = sel_a & ~hit_a;
		scan_b = (~state.dir_b & col_b) | (state.port_b & state.dir_b);
		unique case (reg_address)
			kmps_pkg::REG_PORT_A: read_value = scan_a;
			kmps_pkg::REG_PORT_B: read_value = scan_b;
			kmps_pkg::REG_DIR_A:  read_value = state.dir_a;
			kmps_pkg::REG_DIR_B:  read_value = state.dir_b;
			default:              read_value = state.dir_b;
		endcase
	end

endmodule

### rtl/core/keyboard_matrix_port_scan.sv
// Keyboard matrix port scan: 8x8 key map seen through two I/O ports.
// Top level; instantiates kmps_state and kmps_scan, uses kmps_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per cycle while
//   in_ready is high: a key press, key release, register write or register
//   read. Only a read produces a result item, on the output channel
//   (out_valid/out_ready) as read_value.
//   Throughput: one item per cycle, save in a stall. Every item passes one
//   input register stage; state updates at the end of that cycle, so the
//   next item sees it. A read goes through the input register into the
//   scan; the result register holds the value and raises out_valid.
//   Stall: while a result waits, press/release/write items keep flowing;
//   a second read holds in the input register until the result is taken,
//   and in_ready drops only in that case.
//   Reset: arst_n low clears the key map to no keys pressed and all port
//   and direction registers to zero; both pipeline slots come up empty.
module keyboard_matrix_port_scan (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [2:0] key_group,
	input  logic [2:0] key_bit,
	input  logic       with_shift,
	input  logic [1:0] reg_address,
	input  logic [7:0] write_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_value
);

	logic                  valid_s1;
	kmps_pkg::item_t       item_s1;
	kmps_pkg::item_t       upd;
	kmps_pkg::port_state_t state;
	logic [7:0]            scan_value;
	logic                  is_read;
	logic                  advance;
	logic                  fire;
	logic                  in_fire;
	logic                  out_valid_q;
	logic [7:0]            read_value_q;

	assign is_read  = (item_s1.action == kmps_pkg::ACT_READ);
	assign advance  = !(is_read && out_valid_q && !out_ready);
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.valid       <= 1'b1;
			item_s1.action      <= kmps_pkg::action_t'(action);
			item_s1.key_group   <= key_group;
			item_s1.key_bit     <= key_bit;
			item_s1.with_shift  <= with_shift;
			item_s1.reg_address <= kmps_pkg::reg_addr_t'(reg_address);
			item_s1.write_value <= write_value;
		end
	end

	always_comb begin
		upd       = item_s1;
		upd.valid = fire;
	end

	kmps_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.state  (state)
	);

	kmps_scan u_scan (
		.state       (state),
		.reg_address (item_s1.reg_address),
		.read_value  (scan_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && is_read) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_read) begin
			read_value_q <= scan_value;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;

endmodule

### rtl/core/kmps_checker.sv
// Port-level checker for keyboard_matrix_port_scan, attached by bind.
// Depends on kmps_pkg and keyboard_matrix_port_scan_macros.svh.
`include "keyboard_matrix_port_scan_macros.svh"

module kmps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] action,
	input logic [2:0] key_group,
	input logic [2:0] key_bit,
	input logic       with_shift,
	input logic [1:0] reg_address,
	input logic [7:0] write_value,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_value
);

	logic rd_in;
	assign rd_in = in_valid && (action == kmps_pkg::ACT_READ);

	// a stalled result holds
	`KMPS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(read_value), "result dropped or changed while stalled")

	// input side only backs up behind a stalled result
	`KMPS_ASSERT_IMPLY(a_ready_stall, clk, arst_n, !in_ready, out_valid && !out_ready, "in_ready low without a stalled result")

	// a taken result is not followed by another unless a read was in flight
	`KMPS_ASSERT_NEXT(a_no_extra, clk, arst_n, out_valid && out_ready && $past(in_ready) && !$past(rd_in), !out_valid, "result item with no read accepted")

	// nothing comes out in the first cycle after the output was empty and idle
	`KMPS_ASSERT_NEXT(a_no_spurious, clk, arst_n, !out_valid && !$past(rd_in) && $past(in_ready), !out_valid, "result appeared without a read in flight")

endmodule

bind keyboard_matrix_port_scan kmps_checker u_kmps_checker (.*);
